FILE: sv/color_gradient_table_top_assert.svh
// ----------------------------------------------------------------------------
// color_gradient_table_top_assert.svh
// Assertion macros for the color gradient table.
// ----------------------------------------------------------------------------
`ifndef COLOR_GRADIENT_TABLE_TOP_ASSERT_SVH
`define COLOR_GRADIENT_TABLE_TOP_ASSERT_SVH

// Check a condition at the same edge as its trigger
`define CGT_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger
`define CGT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/cgt_pkg.sv
// ----------------------------------------------------------------------------
// cgt_pkg
// Shared codes and types for the color gradient table.
// ----------------------------------------------------------------------------
`default_nettype none

package cgt_pkg;

   // Operation codes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // Status codes
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_DUP  = 2'd2;
   localparam logic [1:0] ST_MISS = 2'd3;

   // Color of an empty gradient
   localparam logic [7:0] EMPTY_GREY = 8'd128;

   // Request to the blend unit: one channel between two stops
   typedef struct packed {
      logic       start;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] delta;
      logic [7:0] span;
   } blend_req_type;

endpackage

`default_nettype wire

FILE: sv/cgt_ram.sv
// ----------------------------------------------------------------------------
// cgt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cgt_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 255,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: sv/cgt_blend.sv
// ----------------------------------------------------------------------------
// cgt_blend
// One channel of linear interpolation: floor((lo*(span-dist)+hi*dist)/span),
// built from two multiplies, an add and a bit-serial restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module cgt_blend (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cgt_pkg::blend_req_type req,
   output logic                       done,
   output logic [7:0]                 quotient
);

   import cgt_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;

   logic [1:0]  ph_ff, ph_in;
   logic [15:0] p1_ff, p1_in;
   logic [7:0]  hi_ff, hi_in;
   logic [7:0]  dist_ff, dist_in;
   logic [7:0]  span_ff, span_in;
   logic [15:0] num_ff, num_in;
   logic [7:0]  rem_ff, rem_in;
   logic [3:0]  step_ff, step_in;
   logic        done_ff, done_in;
   logic [8:0]  trial;
   logic        fits;

   // Trial subtract of one divide step
   assign trial = {rem_ff, num_ff[15]};
   assign fits  = (trial >= {1'b0, span_ff});

   // Sequence multiply, add, then sixteen divide steps
   always_comb begin
      ph_in   = ph_ff;
      p1_in   = p1_ff;
      hi_in   = hi_ff;
      dist_in = dist_ff;
      span_in = span_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      done_in = 1'b0;
      case (ph_ff)
         PH_IDLE: begin
            if (req.start) begin
               p1_in   = req.lo * 8'(req.span - req.delta);
               hi_in   = req.hi;
               dist_in = req.delta;
               span_in = req.span;
               ph_in   = PH_MUL;
            end
         end
         PH_MUL: begin
            num_in  = 16'(p1_ff + hi_ff * dist_ff);
            rem_in  = '0;
            step_in = '0;
            ph_in   = PH_DIV;
         end
         PH_DIV: begin
            rem_in  = fits ? 8'(trial - {1'b0, span_ff}) : trial[7:0];
            num_in  = {num_ff[14:0], fits};
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               done_in = 1'b1;
               ph_in   = PH_IDLE;
            end
         end
         default: begin
            ph_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= PH_IDLE;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= done_in;
      end
      p1_ff   <= p1_in;
      hi_ff   <= hi_in;
      dist_ff <= dist_in;
      span_ff <= span_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   // Quotient never exceeds the larger endpoint, so it fits eight bits
   assign done     = done_ff;
   assign quotient = num_ff[7:0];

endmodule

`default_nettype wire

FILE: sv/color_gradient_table_top.sv
// ----------------------------------------------------------------------------
// color_gradient_table_top
// Sorted table of color stops with add, remove and interpolated lookup.
// ----------------------------------------------------------------------------
// The stops live in one RAM with a registered read, so one entry is read and
// one written per cycle. An add or remove is a scan up to the stop's place
// followed by a shift of the entries above it. A lookup scans to find the two
// stops around the position and, when it falls between them, makes three
// passes through a shared bit-serial divider. One item is handled at a time;
// a finished result waits in an output register while the next item is
// taken. No clearing pass runs after reset.
`default_nettype none

`include "color_gradient_table_top_assert.svh"

module color_gradient_table_top #(
   parameter int CAPACITY = 255
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_position,
   input  wire logic [7:0] req_red_in,
   input  wire logic [7:0] req_green_in,
   input  wire logic [7:0] req_blue_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_red_out,
   output logic [7:0]      rsp_green_out,
   output logic [7:0]      rsp_blue_out,
   output logic [1:0]      rsp_status,
   output logic [7:0]      rsp_stops_held
);

   import cgt_pkg::*;

   localparam int         AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [7:0] CAP_COUNT = 8'(CAPACITY);

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_SCAN       = 3'd1;
   localparam logic [2:0] S_SHIFT      = 3'd2;
   localparam logic [2:0] S_BLEND_GO   = 3'd3;
   localparam logic [2:0] S_BLEND_WAIT = 3'd4;
   localparam logic [2:0] S_DONE       = 3'd5;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   logic [2:0]  state_ff, state_in;
   logic [7:0]  count_ff, count_in;
   logic [1:0]  op_ff, op_in;
   logic [7:0]  pos_ff, pos_in;
   logic [23:0] color_ff, color_in;
   logic [7:0]  ptr_ff, ptr_in;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  tgt_ff, tgt_in;
   logic        pend_ff, pend_in;
   logic [7:0]  idx_ff, idx_in;
   logic [31:0] prev_ff, prev_in;
   logic [31:0] cur_ff, cur_in;
   logic [1:0]  ch_ff, ch_in;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  blue_ff, blue_in;
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_red_ff, rsp_red_in;
   logic [7:0]  rsp_green_ff, rsp_green_in;
   logic [7:0]  rsp_blue_ff, rsp_blue_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_count_ff, rsp_count_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [31:0]   ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic [31:0]   ram_rdata;

   blend_req_type blend_req;
   logic          blend_done;
   logic [7:0]    blend_quo;

   logic [7:0] rd_pos;
   logic       scan_cond;
   logic       hit_now;
   logic       match_now;
   logic       scan_issue;
   logic       shift_down;
   logic [7:0] prev_pos;
   logic [7:0] cur_pos;

   // Stop table
   cgt_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Shared interpolation unit
   cgt_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .req      (blend_req),
      .done     (blend_done),
      .quotient (blend_quo)
   );

   // Scan compare on the entry coming back from the table
   assign rd_pos     = ram_rdata[31:24];
   assign scan_cond  = (op_ff == OP_LOOKUP) ? (pos_ff < rd_pos) : (pos_ff <= rd_pos);
   assign hit_now    = pend_ff && scan_cond;
   assign match_now  = hit_now && (rd_pos == pos_ff);
   assign scan_issue = (ptr_ff < count_ff) && !hit_now;
   assign shift_down = (op_ff == OP_ADD);
   assign prev_pos   = prev_ff[31:24];
   assign cur_pos    = cur_ff[31:24];

   // Feed one channel of the bracketing stops to the blend unit
   always_comb begin
      blend_req.start = (state_ff == S_BLEND_GO);
      blend_req.delta = pos_ff - prev_pos;
      blend_req.span  = cur_pos - prev_pos;
      case (ch_ff)
         CH_RED: begin
            blend_req.lo = prev_ff[23:16];
            blend_req.hi = cur_ff[23:16];
         end
         CH_GREEN: begin
            blend_req.lo = prev_ff[15:8];
            blend_req.hi = cur_ff[15:8];
         end
         default: begin
            blend_req.lo = prev_ff[7:0];
            blend_req.hi = cur_ff[7:0];
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      color_in      = color_ff;
      ptr_in        = ptr_ff;
      rem_in        = rem_ff;
      tgt_in        = tgt_ff;
      pend_in       = 1'b0;
      idx_in        = idx_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      ch_in         = ch_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_red_in    = rsp_red_ff;
      rsp_green_in  = rsp_green_ff;
      rsp_blue_in   = rsp_blue_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = '0;

      case (state_ff)
         S_IDLE: begin
            // Take an item and sort out the cases that need no scan
            if (req_valid) begin
               op_in     = req_operation;
               pos_in    = req_position;
               color_in  = {req_red_in, req_green_in, req_blue_in};
               red_in    = '0;
               green_in  = '0;
               blue_in   = '0;
               status_in = ST_DONE;
               ptr_in    = '0;
               case (req_operation)
                  OP_ADD: begin
                     if (count_ff == CAP_COUNT) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_REMOVE: begin
                     state_in = S_SCAN;
                  end
                  OP_LOOKUP: begin
                     if (count_ff == 8'd0) begin
                        red_in   = EMPTY_GREY;
                        green_in = EMPTY_GREY;
                        blue_in  = EMPTY_GREY;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Stream reads upward until the first stop that bounds the position
            if (scan_issue) begin
               ram_re    = 1'b1;
               ram_raddr = ptr_ff[AW-1:0];
               ptr_in    = ptr_ff + 8'd1;
               tgt_in    = ptr_ff;
               pend_in   = 1'b1;
            end
            if (pend_ff && !scan_cond) begin
               prev_in = ram_rdata;
            end
            if (hit_now || (!pend_ff && !scan_issue)) begin
               idx_in = hit_now ? tgt_ff : count_ff;
               cur_in = ram_rdata;
               case (op_ff)
                  OP_ADD: begin
                     if (match_now) begin
                        status_in = ST_DUP;
                        state_in  = S_DONE;
                     end else begin
                        rem_in   = count_ff - (hit_now ? tgt_ff : count_ff);
                        ptr_in   = count_ff - 8'd1;
                        state_in = S_SHIFT;
                     end
                  end
                  OP_REMOVE: begin
                     if (match_now) begin
                        rem_in   = count_ff - 8'd1 - tgt_ff;
                        ptr_in   = tgt_ff + 8'd1;
                        state_in = S_SHIFT;
                     end else begin
                        status_in = ST_MISS;
                        state_in  = S_DONE;
                     end
                  end
                  default: begin
                     if (!hit_now) begin
                        // At or past the last stop
                        red_in   = prev_ff[23:16];
                        green_in = prev_ff[15:8];
                        blue_in  = prev_ff[7:0];
                        state_in = S_DONE;
                     end else if (tgt_ff == 8'd0) begin
                        // Below the first stop
                        red_in   = ram_rdata[23:16];
                        green_in = ram_rdata[15:8];
                        blue_in  = ram_rdata[7:0];
                        state_in = S_DONE;
                     end else begin
                        ch_in    = CH_RED;
                        state_in = S_BLEND_GO;
                     end
                  end
               endcase
            end
         end

         S_SHIFT: begin
            // Move entries one place, read ahead of write
            if (rem_ff != 8'd0) begin
               ram_re    = 1'b1;
               ram_raddr = ptr_ff[AW-1:0];
               ptr_in    = shift_down ? ptr_ff - 8'd1 : ptr_ff + 8'd1;
               tgt_in    = shift_down ? ptr_ff + 8'd1 : ptr_ff - 8'd1;
               rem_in    = rem_ff - 8'd1;
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = tgt_ff[AW-1:0];
               ram_wdata = ram_rdata;
            end
            // Drop the new stop into the gap, or close the gap
            if (rem_ff == 8'd0 && !pend_ff) begin
               if (shift_down) begin
                  ram_we    = 1'b1;
                  ram_waddr = idx_ff[AW-1:0];
                  ram_wdata = {pos_ff, color_ff};
                  count_in  = count_ff + 8'd1;
               end else begin
                  count_in = count_ff - 8'd1;
               end
               state_in = S_DONE;
            end
         end

         S_BLEND_GO: begin
            state_in = S_BLEND_WAIT;
         end

         S_BLEND_WAIT: begin
            // Collect one channel, then start the next one or finish after blue
            if (blend_done) begin
               case (ch_ff)
                  CH_RED: begin
                     red_in = blend_quo;
                  end
                  CH_GREEN: begin
                     green_in = blend_quo;
                  end
                  default: begin
                     blue_in = blend_quo;
                  end
               endcase
               if (ch_ff == CH_BLUE) begin
                  state_in = S_DONE;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = S_BLEND_GO;
               end
            end
         end

         S_DONE: begin
            // Hand the item to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_red_in    = red_ff;
               rsp_green_in  = green_ff;
               rsp_blue_in   = blue_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      color_ff      <= color_in;
      ptr_ff        <= ptr_in;
      rem_ff        <= rem_in;
      tgt_ff        <= tgt_in;
      idx_ff        <= idx_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      ch_ff         <= ch_in;
      red_ff        <= red_in;
      green_ff      <= green_in;
      blue_ff       <= blue_in;
      status_ff     <= status_in;
      rsp_red_ff    <= rsp_red_in;
      rsp_green_ff  <= rsp_green_in;
      rsp_blue_ff   <= rsp_blue_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = rsp_red_ff;
   assign rsp_green_out  = rsp_green_ff;
   assign rsp_blue_out   = rsp_blue_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_stops_held = rsp_count_ff;

   // Checks
   `CGT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CAP_COUNT,
      "stop count above capacity")
   `CGT_ASSERT_NOW(a_write_in_range, clock, reset, ram_we, ram_waddr < CAPACITY,
      "table write outside capacity")
   `CGT_ASSERT_NOW(a_count_from_shift, clock, reset, count_ff != $past(count_ff),
      $past(state_ff) == S_SHIFT, "stop count changed outside shift")
   `CGT_ASSERT_NOW(a_blend_when_waiting, clock, reset, blend_done,
      state_ff == S_BLEND_WAIT, "blend result with no lookup waiting")

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the color gradient table against a built-in predictor that keeps its
// own sorted list of stops. A short stimulus table covers the empty table, the
// end stops, duplicate and missing positions and the unused operation code.
// Random phases with varied sender and receiver idling follow. The last phase
// fills the table to capacity and drains it again.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cgt_pkg::*;

   localparam int STOP_CAPACITY = 255;
   localparam int RANDOM_PER_PHASE = 218;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int DRAIN_CYCLES = 400;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] position;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_stop_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] position;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } gradient_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [1:0] status;
      logic [7:0] held;
   } gradient_rsp_type;

   typedef struct packed {
      gradient_req_type req;
      logic             typed;
      gradient_rsp_type rsp;
   } directed_row_type;

   // Stimulus table; rows with typed set carry their answer, the rest are
   // checked against the predictor
   localparam directed_row_type DIRECTED_ROWS [25] = '{
      '{'{OP_LOOKUP, 8'd0,   8'd0,   8'd0,   8'd0},   1'b1,
        '{EMPTY_GREY, EMPTY_GREY, EMPTY_GREY, ST_DONE, 8'd0}},
      '{'{OP_REMOVE, 8'd5,   8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd0, 8'd0, 8'd0, ST_MISS, 8'd0}},
      '{'{OP_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
        '{8'd0, 8'd0, 8'd0, ST_DONE, 8'd0}},
      '{'{OP_ADD,    8'd100, 8'd10,  8'd20,  8'd30},  1'b1,
        '{8'd0, 8'd0, 8'd0, ST_DONE, 8'd1}},
      '{'{OP_ADD,    8'd100, 8'd1,   8'd2,   8'd3},   1'b1,
        '{8'd0, 8'd0, 8'd0, ST_DUP, 8'd1}},
      '{'{OP_LOOKUP, 8'd0,   8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd10, 8'd20, 8'd30, ST_DONE, 8'd1}},
      '{'{OP_LOOKUP, 8'd255, 8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd10, 8'd20, 8'd30, ST_DONE, 8'd1}},
      '{'{OP_LOOKUP, 8'd100, 8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd10, 8'd20, 8'd30, ST_DONE, 8'd1}},
      '{'{OP_ADD,    8'd0,   8'd255, 8'd255, 8'd255}, 1'b1,
        '{8'd0, 8'd0, 8'd0, ST_DONE, 8'd2}},
      '{'{OP_ADD,    8'd255, 8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd0, 8'd0, 8'd0, ST_DONE, 8'd3}},
      '{'{OP_LOOKUP, 8'd0,   8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd255, 8'd255, 8'd255, ST_DONE, 8'd3}},
      '{'{OP_LOOKUP, 8'd255, 8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd0, 8'd0, 8'd0, ST_DONE, 8'd3}},
      '{'{OP_LOOKUP, 8'd50,  8'd0,   8'd0,   8'd0},   1'b0, '0},
      '{'{OP_LOOKUP, 8'd101, 8'd0,   8'd0,   8'd0},   1'b0, '0},
      '{'{OP_LOOKUP, 8'd254, 8'd0,   8'd0,   8'd0},   1'b0, '0},
      '{'{OP_ADD,    8'd1,   8'd0,   8'd255, 8'd0},   1'b1,
        '{8'd0, 8'd0, 8'd0, ST_DONE, 8'd4}},
      '{'{OP_LOOKUP, 8'd1,   8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd0, 8'd255, 8'd0, ST_DONE, 8'd4}},
      '{'{OP_LOOKUP, 8'd128, 8'd0,   8'd0,   8'd0},   1'b0, '0},
      '{'{OP_REMOVE, 8'd100, 8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd0, 8'd0, 8'd0, ST_DONE, 8'd3}},
      '{'{OP_REMOVE, 8'd100, 8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd0, 8'd0, 8'd0, ST_MISS, 8'd3}},
      '{'{OP_UNUSED, 8'd0,   8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd0, 8'd0, 8'd0, ST_DONE, 8'd3}},
      '{'{OP_REMOVE, 8'd0,   8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd0, 8'd0, 8'd0, ST_DONE, 8'd2}},
      '{'{OP_REMOVE, 8'd255, 8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd0, 8'd0, 8'd0, ST_DONE, 8'd1}},
      '{'{OP_LOOKUP, 8'd200, 8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd0, 8'd255, 8'd0, ST_DONE, 8'd1}},
      '{'{OP_REMOVE, 8'd1,   8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd0, 8'd0, 8'd0, ST_DONE, 8'd0}}
   };

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_operation = OP_LOOKUP;
   logic [7:0] req_position = 8'd0;
   logic [7:0] req_red_in = 8'd0;
   logic [7:0] req_green_in = 8'd0;
   logic [7:0] req_blue_in = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_red_out;
   logic [7:0] rsp_green_out;
   logic [7:0] rsp_blue_out;
   logic [1:0] rsp_status;
   logic [7:0] rsp_stops_held;

   color_stop_type   gradient_stops [$];
   gradient_rsp_type pending_answers [$];
   int               mismatches = 0;
   int               send_idle_pct = 0;
   int               stall_pct = 0;

   color_gradient_table_top #(
      .CAPACITY(STOP_CAPACITY)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_position(req_position),
      .req_red_in(req_red_in),
      .req_green_in(req_green_in),
      .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out),
      .rsp_status(rsp_status),
      .rsp_stops_held(rsp_stops_held)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Truncated linear blend of one channel between two stops
   function automatic logic [7:0] mix_channel(input logic [7:0] lo, input logic [7:0] hi,
                                              input logic [7:0] delta, input logic [7:0] span);
      int unsigned weighted;
      if (span == 8'd0) return lo;
      weighted = int'(lo) * (int'(span) - int'(delta)) + int'(hi) * int'(delta);
      return 8'(weighted / int'(span));
   endfunction

   // Apply one operation to the predicted table and return its answer
   function automatic gradient_rsp_type apply_gradient_op(input gradient_req_type req);
      gradient_rsp_type ans;
      color_stop_type   lo_stop;
      color_stop_type   hi_stop;
      int               idx;
      ans = '0;
      ans.status = ST_DONE;
      case (req.operation)
         OP_ADD: begin
            if (gradient_stops.size() >= STOP_CAPACITY) begin
               ans.status = ST_FULL;
            end else begin
               for (idx = 0; idx < gradient_stops.size(); idx++)
                  if (req.position <= gradient_stops[idx].position) break;
               if (idx < gradient_stops.size() && gradient_stops[idx].position == req.position)
                  ans.status = ST_DUP;
               else
                  gradient_stops.insert(idx, color_stop_type'{req.position, req.red,
                                                              req.green, req.blue});
            end
         end
         OP_REMOVE: begin
            for (idx = 0; idx < gradient_stops.size(); idx++)
               if (gradient_stops[idx].position == req.position) break;
            if (idx >= gradient_stops.size())
               ans.status = ST_MISS;
            else
               gradient_stops.delete(idx);
         end
         OP_LOOKUP: begin
            if (gradient_stops.size() == 0) begin
               ans.red = EMPTY_GREY;
               ans.green = EMPTY_GREY;
               ans.blue = EMPTY_GREY;
            end else begin
               for (idx = 0; idx < gradient_stops.size(); idx++)
                  if (req.position < gradient_stops[idx].position) break;
               // clamp to the end stops outside the covered range
               if (idx == 0 || idx == gradient_stops.size()) begin
                  lo_stop = (idx == 0) ? gradient_stops[0] : gradient_stops[$];
                  ans.red = lo_stop.red;
                  ans.green = lo_stop.green;
                  ans.blue = lo_stop.blue;
               end else begin
                  lo_stop = gradient_stops[idx - 1];
                  hi_stop = gradient_stops[idx];
                  ans.red = mix_channel(lo_stop.red, hi_stop.red,
                                        req.position - lo_stop.position,
                                        hi_stop.position - lo_stop.position);
                  ans.green = mix_channel(lo_stop.green, hi_stop.green,
                                          req.position - lo_stop.position,
                                          hi_stop.position - lo_stop.position);
                  ans.blue = mix_channel(lo_stop.blue, hi_stop.blue,
                                         req.position - lo_stop.position,
                                         hi_stop.position - lo_stop.position);
               end
            end
         end
         default: begin
            // unused code: no change, zero colors
         end
      endcase
      ans.held = 8'(gradient_stops.size());
      return ans;
   endfunction

   function automatic gradient_req_type random_request(input logic [1:0] op,
                                                        input logic [7:0] pos);
      gradient_req_type req;
      req.operation = op;
      req.position = pos;
      req.red = 8'($urandom);
      req.green = 8'($urandom);
      req.blue = 8'($urandom);
      return req;
   endfunction

   function automatic logic [7:0] held_position();
      return gradient_stops[$urandom_range(gradient_stops.size() - 1)].position;
   endfunction

   // Draw a random item, steering the table size toward a target
   function automatic gradient_req_type draw_request(input int target);
      int         roll;
      logic       have_stops;
      logic [7:0] pos;
      logic [1:0] op;
      have_stops = (gradient_stops.size() != 0);
      roll = $urandom_range(99);
      pos = 8'($urandom_range(255));
      if (gradient_stops.size() < target)
         op = (roll < 45) ? OP_ADD : (roll < 60) ? OP_REMOVE : (roll < 95) ? OP_LOOKUP : OP_UNUSED;
      else
         op = (roll < 15) ? OP_ADD : (roll < 55) ? OP_REMOVE : (roll < 95) ? OP_LOOKUP : OP_UNUSED;
      case (op)
         OP_ADD:
            if (have_stops && $urandom_range(4) == 0) pos = held_position();
         OP_REMOVE:
            if (have_stops && $urandom_range(9) < 7) pos = held_position();
         OP_LOOKUP: begin
            roll = $urandom_range(2);
            if (have_stops && roll == 1) pos = held_position();
            else if (have_stops && roll == 2) pos = held_position() + 8'($urandom_range(6)) - 8'd3;
         end
         default: ;
      endcase
      return random_request(op, pos);
   endfunction

   // Present one item, wait for its handshake and record its answer
   task automatic drive_item(input gradient_req_type req, input logic typed,
                             input gradient_rsp_type typed_rsp);
      gradient_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= req.operation;
      req_position <= req.position;
      req_red_in <= req.red;
      req_green_in <= req.green;
      req_blue_in <= req.blue;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_gradient_op(req);
      pending_answers.push_back(typed ? typed_rsp : predicted);
   endtask

   function automatic void shuffle_positions(output logic [7:0] order [256]);
      int         pick;
      logic [7:0] tmp;
      for (int k = 0; k < 256; k++) order[k] = 8'(k);
      for (int k = 255; k > 0; k--) begin
         pick = $urandom_range(k);
         tmp = order[k];
         order[k] = order[pick];
         order[pick] = tmp;
      end
   endfunction

   // Fill the table to capacity, press on it while full, then drain it
   task automatic sweep_full_table();
      logic [7:0] order [256];
      shuffle_positions(order);
      for (int k = 0; k < 256; k++)
         drive_item(random_request(OP_ADD, order[k]), 1'b0, '0);
      for (int k = 0; k < 24; k++)
         drive_item(random_request(OP_LOOKUP, 8'($urandom_range(255))), 1'b0, '0);
      for (int k = 0; k < 4; k++)
         drive_item(random_request(OP_ADD, 8'($urandom_range(255))), 1'b0, '0);
      shuffle_positions(order);
      for (int k = 0; k < 256; k++) begin
         drive_item(random_request(OP_REMOVE, order[k]), 1'b0, '0);
         if (k % 16 == 15)
            drive_item(random_request(OP_LOOKUP, 8'($urandom_range(255))), 1'b0, '0);
      end
   endtask

   task automatic compare_field(input string label, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   // Check each result against the oldest answer, then pick the next stall
   always @(posedge clock) begin : answer_check
      gradient_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %0d %0d %0d status %0d held %0d",
                     $time, rsp_red_out, rsp_green_out, rsp_blue_out, rsp_status,
                     rsp_stops_held);
            mismatches++;
         end else begin
            want = pending_answers.pop_front();
            compare_field("red", want.red, rsp_red_out);
            compare_field("green", want.green, rsp_green_out);
            compare_field("blue", want.blue, rsp_blue_out);
            compare_field("status", 8'(want.status), 8'(rsp_status));
            compare_field("stops_held", want.held, rsp_stops_held);
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Hard stop on a hung run
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout with %0d results outstanding", $time, pending_answers.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int target;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED_ROWS[k])
         drive_item(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].rsp);

      // random phases with different idling
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  target = 4;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  target = 16; end
            2: begin send_idle_pct = 0;  stall_pct = 70; target = 40; end
            default: begin send_idle_pct = 13; stall_pct = 13; target = 8; end
         endcase
         repeat (RANDOM_PER_PHASE) drive_item(draw_request(target), 1'b0, '0);
         if (phase == 3) sweep_full_table();
      end
      req_valid <= 1'b0;

      // drain outstanding answers, then watch for stray results
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/cgt_pkg.sv
sv/cgt_ram.sv
sv/cgt_blend.sv
sv/color_gradient_table_top.sv
sim/testbench.sv
